// ----- rtl/particle_swarm_update_engine_assert.svh -----
// Assertion macros for the particle swarm update engine.
// Used by the top level only; no other dependencies.
`ifndef PARTICLE_SWARM_UPDATE_ENGINE_ASSERT_SVH
`define PARTICLE_SWARM_UPDATE_ENGINE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define PSU_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// Next-cycle implication checked on every clock edge outside reset.
`define PSU_ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

// ----- rtl/psu_pkg.sv -----
// Shared constants for the particle swarm update engine.
// No dependencies.
package psu_pkg;
  localparam logic [1:0] MODE_SEED     = 2'd0;
  localparam logic [1:0] MODE_EVAL     = 2'd1;
  localparam logic [1:0] MODE_UPDATE   = 2'd2;
  localparam logic [1:0] MODE_RESERVED = 2'd3;
  localparam logic [2:0] REG_COG    = 3'd0;
  localparam logic [2:0] REG_SOC    = 3'd1;
  localparam logic [2:0] REG_VLIM   = 3'd2;
  localparam logic [2:0] REG_PLOW   = 3'd3;
  localparam logic [2:0] REG_PHIGH  = 3'd4;
  localparam logic [2:0] REG_DLOW   = 3'd5;
  localparam logic [2:0] REG_DHIGH  = 3'd6;
endpackage

// ----- rtl/particle_swarm_update_engine.sv -----
// Particle swarm update engine, top level.
// Depends on psu_pkg and particle_swarm_update_engine_assert.svh.
//
// Usage: requests arrive on in_valid/in_stall with one port per field; each
// request produces exactly one result on out_valid/out_stall. The block holds
// one request at a time: in_stall is high while a request is worked on and
// while a finished result waits under out_stall. A seed or an ignored request
// goes straight to the output state. An update reads the element, then takes
// five multiply steps on one shared signed multiplier and a final clamp step;
// an evaluate walks the position memory one dimension at a time, through a
// read state and a write state for each dimension. The result holds while
// out_stall is high, and the next request can be accepted on the cycle that
// result is taken. Configuration writes use cfg_valid/cfg_ready; cfg_ready is
// always high and writes are meant for idle periods only. Reset (rst,
// synchronous) restores the default gains and bounds and clears every
// personal best and the swarm best. Position, velocity and best position
// memories are not cleared: an element must be seeded before it is updated
// or evaluated, and the block is ready the cycle after reset.
`include "particle_swarm_update_engine_assert.svh"
module particle_swarm_update_engine #(
  parameter int PARTICLES = 32,
  parameter int DIMENSIONS = 6,
  parameter int PROP_DIMENSIONS = 3
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [1:0] mode,
  input  logic [4:0] particle,
  input  logic [2:0] dimension,
  input  logic signed [15:0] position_in,
  input  logic signed [15:0] velocity_in,
  input  logic [31:0] cost,
  input  logic cost_valid,
  input  logic [12:0] inertia,
  input  logic [15:0] rand_cognitive,
  input  logic [15:0] rand_social,
  output logic out_valid,
  input  logic out_stall,
  output logic signed [15:0] position_out,
  output logic signed [15:0] velocity_out,
  output logic new_personal_best,
  output logic new_global_best,
  output logic [31:0] swarm_cost,
  output logic have_global_best,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data
);
  localparam int ELEMS = PARTICLES * DIMENSIONS;
  localparam int EW = (ELEMS > 1) ? $clog2(ELEMS) : 1;
  localparam int PW = $clog2(PARTICLES);
  localparam int DW = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;

  localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_M0 = 4'd2, S_M1 = 4'd3,
    S_M2 = 4'd4, S_M3 = 4'd5, S_M4 = 4'd6, S_FIN = 4'd7, S_EV = 4'd8,
    S_EVW = 4'd9, S_OUT = 4'd10, S_SOC = 4'd11;

  logic [14:0] cog, soc, vlim;
  logic signed [15:0] plow, phigh, dlow, dhigh;
  logic [3:0] state;

  logic signed [15:0] pos_mem [ELEMS];
  logic signed [15:0] vel_mem [ELEMS];
  logic signed [15:0] bpos_mem [ELEMS];
  logic [31:0] bcost [PARTICLES];
  logic [PARTICLES-1:0] bvalid;
  logic signed [15:0] gpos [DIMENSIONS];
  logic [31:0] gcost;
  logic gvalid;

  logic [PW-1:0] r_p;
  logic [DW-1:0] r_d;
  logic [EW-1:0] r_e;
  logic [31:0] r_cost;
  logic r_cv;
  logic [12:0] r_w;
  logic [15:0] r_r1, r_r2;
  logic signed [15:0] x, v, bp, gp;
  logic [DW-1:0] k;
  logic upd_pb, upd_gb;
  logic signed [15:0] rd_pos;

  // Shared multiplier: one signed product per cycle, registered.
  logic signed [32:0] ma, mb;
  logic signed [65:0] mprod;
  logic signed [47:0] prod_q;
  logic signed [31:0] gr;
  // The inertia term and both pull terms together need 22 bits before the clamp.
  logic signed [21:0] acc;

  logic p_ok, d_ok;
  logic signed [16:0] lo, hi;
  logic signed [19:0] nvc;
  logic signed [20:0] nx;
  logic signed [19:0] term;

  assign cfg_ready = 1'b1;
  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign swarm_cost = gcost;
  assign have_global_best = gvalid;
  assign p_ok = ({27'd0, particle} < 32'(PARTICLES));
  assign d_ok = ({29'd0, dimension} < 32'(DIMENSIONS));
  assign lo = (32'(r_d) < 32'(PROP_DIMENSIONS)) ? 17'(plow) : 17'(dlow);
  assign hi = (32'(r_d) < 32'(PROP_DIMENSIONS)) ? 17'(phigh) : 17'(dhigh);

  function automatic logic signed [16:0] lo_in(input logic [2:0] d);
    lo_in = (32'(d) < 32'(PROP_DIMENSIONS)) ? 17'(plow) : 17'(dlow);
  endfunction
  function automatic logic signed [16:0] hi_in(input logic [2:0] d);
    hi_in = (32'(d) < 32'(PROP_DIMENSIONS)) ? 17'(phigh) : 17'(dhigh);
  endfunction
  function automatic logic signed [20:0] clamp_x(input logic signed [20:0] a,
      input logic signed [16:0] l, input logic signed [16:0] h);
    clamp_x = (a < 21'(l)) ? 21'(l) : (a > 21'(h)) ? 21'(h) : a;
  endfunction
  // At a bound the velocity becomes minus half of itself, truncated toward zero.
  function automatic logic signed [19:0] bounce_v(input logic signed [20:0] a,
      input logic signed [19:0] nv, input logic signed [16:0] l,
      input logic signed [16:0] h);
    logic signed [19:0] half;
    half = (nv < 0) ? -((-nv) >>> 1) : (nv >>> 1);
    bounce_v = (a < 21'(l) || a > 21'(h)) ? -half : nv;
  endfunction

  assign mprod = ma * mb;
  // Round half up of a Q.28 product to whole position units (pull terms); inertia uses Q.12.
  always_comb begin
    term = 20'(($signed(prod_q) + 48'sd134217728) >>> 28);
    nvc = 20'(acc);
    if (acc > $signed({7'd0, vlim})) nvc = 20'($signed({7'd0, vlim}));
    else if (acc < -$signed({7'd0, vlim})) nvc = 20'(-$signed({7'd0, vlim}));
    nx = 21'(x) + 21'(nvc);
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_M0: begin ma = 33'($signed({1'b0, r_w})); mb = 33'(v); end
      S_M1: begin ma = 33'($signed({1'b0, cog})); mb = 33'($signed({1'b0, r_r1})); end
      S_M2: begin ma = 33'(gr); mb = 33'(bp) - 33'(x); end
      S_M3: begin ma = 33'($signed({1'b0, soc})); mb = 33'($signed({1'b0, r_r2})); end
      S_M4: begin ma = 33'(gr); mb = 33'(gp) - 33'(x); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // Element memories: all reads and writes are clocked.
  always_ff @(posedge clk) begin
    rd_pos <= pos_mem[(state == S_EV) ? EW'(r_p * DIMENSIONS + k) : r_e];
    if (state == S_RD) begin
      x <= pos_mem[r_e];
      v <= vel_mem[r_e];
      bp <= bpos_mem[r_e];
      gp <= gpos[r_d];
    end
    if (!rst && in_valid && !in_stall && mode == psu_pkg::MODE_SEED && p_ok && d_ok) begin
      pos_mem[EW'(particle * DIMENSIONS + dimension)] <=
        16'((17'(position_in) < lo_in(dimension)) ? lo_in(dimension) :
            (17'(position_in) > hi_in(dimension)) ? hi_in(dimension) : 17'(position_in));
      bpos_mem[EW'(particle * DIMENSIONS + dimension)] <=
        16'((17'(position_in) < lo_in(dimension)) ? lo_in(dimension) :
            (17'(position_in) > hi_in(dimension)) ? hi_in(dimension) : 17'(position_in));
      vel_mem[EW'(particle * DIMENSIONS + dimension)] <= velocity_in;
    end
    if (state == S_FIN) begin
      pos_mem[r_e] <= 16'(clamp_x(nx, lo, hi));
      vel_mem[r_e] <= 16'(bounce_v(nx, nvc, lo, hi));
    end
    if (state == S_EVW && upd_pb) bpos_mem[EW'(r_p * DIMENSIONS + k)] <= rd_pos;
  end

  always_ff @(posedge clk) begin
    prod_q <= 48'(mprod);
    // Keep gain times fraction for the pull product of the following cycle.
    if (state == S_M1 || state == S_M3) gr <= 32'(mprod);
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      cog <= 15'd6144; soc <= 15'd6144; vlim <= 15'd1229;
      plow <= -16'sd32768; phigh <= -16'sd20480;
      dlow <= -16'sd20480; dhigh <= -16'sd4096;
      bvalid <= '0;
      for (int i = 0; i < PARTICLES; i++) bcost[i] <= '1;
      gcost <= '1;
      gvalid <= 1'b0;
      for (int i = 0; i < DIMENSIONS; i++) gpos[i] <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          psu_pkg::REG_COG:   cog <= cfg_data[14:0];
          psu_pkg::REG_SOC:   soc <= cfg_data[14:0];
          psu_pkg::REG_VLIM:  vlim <= cfg_data[14:0];
          psu_pkg::REG_PLOW:  plow <= cfg_data;
          psu_pkg::REG_PHIGH: phigh <= cfg_data;
          psu_pkg::REG_DLOW:  dlow <= cfg_data;
          psu_pkg::REG_DHIGH: dhigh <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            r_p <= particle[PW-1:0];
            r_d <= dimension[DW-1:0];
            r_e <= EW'(particle * DIMENSIONS + dimension);
            r_cost <= cost;
            r_cv <= cost_valid;
            r_w <= inertia;
            r_r1 <= rand_cognitive;
            r_r2 <= rand_social;
            k <= '0;
            position_out <= '0;
            velocity_out <= '0;
            new_personal_best <= 1'b0;
            new_global_best <= 1'b0;
            upd_pb <= 1'b0;
            upd_gb <= 1'b0;
            state <= S_OUT;
            if (mode == psu_pkg::MODE_SEED && p_ok && d_ok) begin
              position_out <= 16'((17'(position_in) < lo_in(dimension)) ? lo_in(dimension) :
                (17'(position_in) > hi_in(dimension)) ? hi_in(dimension) : 17'(position_in));
              velocity_out <= velocity_in;
              bvalid[particle[PW-1:0]] <= 1'b0;
              bcost[particle[PW-1:0]] <= '1;
            end else if (mode == psu_pkg::MODE_EVAL && p_ok) begin
              state <= S_EV;
            end else if (mode == psu_pkg::MODE_UPDATE && p_ok && d_ok) begin
              state <= S_RD;
            end
          end
        end
        S_RD: state <= S_M0;
        S_M0: state <= S_M1;
        S_M1: begin
          acc <= 22'(($signed(prod_q) + 48'sd2048) >>> 12);
          state <= S_M2;
        end
        S_M2: state <= S_M3;
        S_M3: begin
          if (bvalid[r_p]) acc <= acc + 22'(term);
          state <= S_M4;
        end
        S_M4: state <= S_SOC;
        S_SOC: begin
          if (gvalid) acc <= acc + 22'(term);
          state <= S_FIN;
        end
        S_FIN: begin
          position_out <= 16'(clamp_x(nx, lo, hi));
          velocity_out <= 16'(bounce_v(nx, nvc, lo, hi));
          state <= S_OUT;
        end
        S_EV: begin
          // For k zero, decide the updates; the memory read of element k is in flight.
          if (k == '0) begin
            upd_pb <= r_cv && (r_cost < bcost[r_p]);
            upd_gb <= r_cv && (r_cost < gcost);
          end
          state <= S_EVW;
        end
        S_EVW: begin
          if (upd_gb) gpos[k] <= rd_pos;
          if (32'(k) == DIMENSIONS - 1) begin
            if (upd_pb) begin
              bcost[r_p] <= r_cost;
              bvalid[r_p] <= 1'b1;
            end
            if (upd_gb) begin
              gcost <= r_cost;
              gvalid <= 1'b1;
            end
            new_personal_best <= upd_pb;
            new_global_best <= upd_gb;
            state <= S_OUT;
          end else begin
            k <= k + 1'b1;
            state <= S_EV;
          end
        end
        S_OUT: begin
          // The output register is always free here, since no request is
          // accepted while a result waits.
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PSU_ASSERT_IMP(a_busy_no_accept, clk, rst, state != S_IDLE, in_stall)
  `PSU_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(position_out))
  `PSU_ASSERT_IMP(a_gb_flag, clk, rst, out_valid && new_global_best, have_global_best)
endmodule
